// ===== design/iee_pkg.sv =====
// shared types and constants for the infix expression evaluator
package iee_pkg;

    // operator codes held on the operator stack
    typedef enum logic [2:0] {
        OP_LPAR = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_MOD  = 3'd5,
        OP_POW  = 3'd6,
        OP_NONE = 3'd7
    } op_code_t;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // character codes
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_PCT   = 8'd37;
    localparam logic [7:0] CH_CARET = 8'd94;
    localparam logic [7:0] CH_LPAR  = 8'd40;
    localparam logic [7:0] CH_RPAR  = 8'd41;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // map a character to its operator code
    function automatic op_code_t char_to_op(input logic [7:0] ch);
        op_code_t r;
        r = OP_NONE;
        case (ch)
            CH_PLUS:  r = OP_ADD;
            CH_MINUS: r = OP_SUB;
            CH_STAR:  r = OP_MUL;
            CH_SLASH: r = OP_DIV;
            CH_PCT:   r = OP_MOD;
            CH_CARET: r = OP_POW;
            default:  r = OP_NONE;
        endcase
        return r;
    endfunction

    // operator precedence
    function automatic logic [1:0] op_prec(input op_code_t c);
        logic [1:0] p;
        case (c)
            OP_ADD, OP_SUB:         p = 2'd1;
            OP_MUL, OP_DIV, OP_MOD: p = 2'd2;
            OP_POW:                 p = 2'd3;
            default:                p = 2'd0;
        endcase
        return p;
    endfunction

    // request from sequencer to the arithmetic unit
    typedef struct packed {
        logic     start;
        op_code_t op;
    } alu_req_t;

    // answer from the arithmetic unit
    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_rsp_t;

endpackage

// ===== design/iee_alu.sv =====
// multi-cycle shared arithmetic unit: add, subtract, multiply, divide, modulo, power
module iee_alu #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  iee_pkg::alu_req_t      req,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output iee_pkg::alu_rsp_t      rsp,
    output logic [VALUE_WIDTH-1:0] result
);
    import iee_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W + 1);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_DIV  = 4'b0010,
        A_POW  = 4'b0100,
        A_DONE = 4'b1000
    } alu_state_t;

    alu_state_t     state_reg, state_next;
    op_code_t       op_reg, op_next;
    logic [W-1:0]   res_reg, res_next;
    logic [W-1:0]   base_reg, base_next;
    logic [W-1:0]   exp_reg, exp_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [W-1:0]   quo_reg, quo_next;
    logic [W-1:0]   dvs_reg, dvs_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           qneg_reg, qneg_next;
    logic           rneg_reg, rneg_next;
    logic           mulsel_reg, mulsel_next;
    logic           dz_reg, dz_next;

    logic [W-1:0]   mul_a, mul_b, mul_p;
    logic [W-1:0]   a_mag, b_mag;
    logic [W:0]     shl, sub;

    // one shared multiplier, operands picked by the sequencer
    always_comb
    begin
        mul_a = a;
        mul_b = b;
        if (state_reg == A_POW)
        begin
            mul_a = mulsel_reg ? base_reg : res_reg;
            mul_b = base_reg;
        end
    end
    assign mul_p = W'(mul_a * mul_b);

    assign a_mag = a[W-1] ? W'(-a) : a;
    assign b_mag = b[W-1] ? W'(-b) : b;

    // restoring divide step
    assign shl = {rem_reg, quo_reg[W-1]};
    assign sub = shl - {1'b0, dvs_reg};

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        res_next    = res_reg;
        base_next   = base_reg;
        exp_next    = exp_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        cnt_next    = cnt_reg;
        qneg_next   = qneg_reg;
        rneg_next   = rneg_reg;
        mulsel_next = mulsel_reg;
        dz_next     = dz_reg;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    dz_next    = 1'b0;
                    state_next = A_DONE;
                    case (req.op)
                        OP_ADD: res_next = a + b;
                        OP_SUB: res_next = a - b;
                        OP_MUL: res_next = mul_p;
                        OP_DIV, OP_MOD:
                        begin
                            if (b == '0)
                            begin
                                res_next = '0;
                                dz_next  = 1'b1;
                            end
                            else
                            begin
                                quo_next   = a_mag;
                                rem_next   = '0;
                                dvs_next   = b_mag;
                                qneg_next  = a[W-1] ^ b[W-1];
                                rneg_next  = a[W-1];
                                cnt_next   = CW'(W);
                                state_next = A_DIV;
                            end
                        end
                        OP_POW:
                        begin
                            if (b[W-1])
                            begin
                                if (a == W'(1))
                                    res_next = W'(1);
                                else if (a == '1)
                                    res_next = b[0] ? '1 : W'(1);
                                else
                                begin
                                    res_next = '0;
                                    dz_next  = (a == '0);
                                end
                            end
                            else
                            begin
                                res_next    = W'(1);
                                base_next   = a;
                                exp_next    = b;
                                cnt_next    = CW'(W);
                                mulsel_next = 1'b0;
                                state_next  = A_POW;
                            end
                        end
                        default: res_next = '0;
                    endcase
                end
            end
            A_DIV:
            begin
                if (sub[W])
                begin
                    rem_next = shl[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                else
                begin
                    rem_next = sub[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    if (op_reg == OP_DIV)
                        res_next = qneg_reg ? W'(-quo_next) : quo_next;
                    else
                        res_next = rneg_reg ? W'(-rem_next) : rem_next;
                    state_next = A_DONE;
                end
            end
            A_POW:
            begin
                // per exponent bit: multiply result if the bit is set, then square base
                if (!mulsel_reg)
                begin
                    if (exp_reg[0])
                        res_next = mul_p;
                    mulsel_next = 1'b1;
                end
                else
                begin
                    base_next   = mul_p;
                    exp_next    = exp_reg >> 1;
                    mulsel_next = 1'b0;
                    cnt_next    = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1) || exp_next == '0)
                        state_next = A_DONE;
                end
            end
            A_DONE:  state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= A_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        res_reg    <= res_next;
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        cnt_reg    <= cnt_next;
        qneg_reg   <= qneg_next;
        rneg_reg   <= rneg_next;
        mulsel_reg <= mulsel_next;
        dz_reg     <= dz_next;
    end

    assign rsp.done     = (state_reg == A_DONE);
    assign rsp.div_zero = dz_reg;
    assign result       = res_reg;

endmodule

// ===== design/infix_expression_evaluator_unit.sv =====
// top level: character sequencer, two stacks and shared arithmetic unit
//
//  channel | signals                                | direction
//  --------+----------------------------------------+----------
//  in      | in_valid in_ready char_code last_char  | request in
//  out     | out_valid out_ready value status       | result out
//
// a digit or ignored character is handled in S_CHAR; an operator or paren
// goes on to S_CHECK, and each operator applied passes S_OPRD, S_POPB, S_POPA,
// S_EXEC and S_WAIT, where the arithmetic unit iterates for / % and ^ (not for
// a zero divisor or a negative exponent); a paren dropped in the flush passes
// S_OPRD; the last character goes through S_FIN and the flush to S_OUT.
// reset clears counters and state; stack contents are not cleared. in_ready is
// low while a character is being worked on; a finished result holds in S_OUT
// while the previous one still waits in the output register.
module infix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] value,
    output logic [1:0]  status
);
    import iee_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHAR  = 10'b0000000010,
        S_CHECK = 10'b0000000100,
        S_OPRD  = 10'b0000001000,
        S_POPB  = 10'b0000010000,
        S_POPA  = 10'b0000100000,
        S_EXEC  = 10'b0001000000,
        S_WAIT  = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } seq_state_t;

    // stacks
    logic [2:0]   ostk [STACK_DEPTH];
    logic [W-1:0] vstk [STACK_DEPTH];
    logic [2:0]   otop_reg;
    logic [W-1:0] vtop_reg;

    seq_state_t   state_reg, state_next;
    logic [CW-1:0] ocnt_reg, ocnt_next;
    logic [CW-1:0] vcnt_reg, vcnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic          innum_reg, innum_next;
    logic [1:0]    err_reg, err_next;
    logic [7:0]    ch_reg;
    logic          last_reg;
    op_code_t      curop_reg, curop_next;
    op_code_t      exop_reg, exop_next;
    logic          flush_reg, flush_next;
    logic          rpar_reg, rpar_next;
    logic [W-1:0]  a_reg, a_next, b_reg, b_next;
    logic [31:0]   val_reg, val_next;
    logic [1:0]    st_reg, st_next;
    logic          out_valid_reg, out_valid_next, out_valid_reg_set;

    logic          opush, vpush;
    logic [2:0]    opush_d;
    logic [W-1:0]  vpush_d;
    logic [AW-1:0] ord_addr, vrd_addr;
    alu_req_t      areq;
    alu_rsp_t      arsp;
    logic [W-1:0]  ares;
    op_code_t      chop, topop;
    logic          is_digit;

    assign is_digit = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign chop     = char_to_op(ch_reg);
    assign topop    = op_code_t'(otop_reg);

    iee_alu #(.VALUE_WIDTH(W)) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (areq),
        .a      (a_reg),
        .b      (b_reg),
        .rsp    (arsp),
        .result (ares)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ocnt_next  = ocnt_reg;
        vcnt_next  = vcnt_reg;
        acc_next   = acc_reg;
        innum_next = innum_reg;
        err_next   = err_reg;
        curop_next = curop_reg;
        exop_next  = exop_reg;
        flush_next = flush_reg;
        rpar_next  = rpar_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        val_next   = val_reg;
        st_next    = st_reg;
        opush      = 1'b0;
        opush_d    = OP_LPAR;
        vpush      = 1'b0;
        vpush_d    = acc_reg;
        areq.start = 1'b0;
        areq.op    = exop_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHAR;
            end
            S_CHAR:
            begin
                flush_next = 1'b0;
                rpar_next  = 1'b0;
                if (is_digit)
                begin
                    acc_next   = W'(acc_reg * W'(10)) + W'(ch_reg - CH_ZERO);
                    innum_next = 1'b1;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
                else
                begin
                    if (innum_reg)
                    begin
                        if (vcnt_reg >= CW'(STACK_DEPTH))
                        begin
                            if (err_reg == ST_OK) err_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            vpush     = 1'b1;
                            vcnt_next = vcnt_reg + CW'(1);
                        end
                        acc_next   = '0;
                        innum_next = 1'b0;
                    end
                    curop_next = chop;
                    if (chop != OP_NONE)
                        state_next = S_CHECK;
                    else if (ch_reg == CH_LPAR)
                    begin
                        curop_next = OP_LPAR;
                        state_next = S_CHECK;
                    end
                    else if (ch_reg == CH_RPAR)
                    begin
                        rpar_next  = 1'b1;
                        state_next = S_CHECK;
                    end
                    else
                        state_next = last_reg ? S_FIN : S_IDLE;
                end
            end
            S_CHECK:
            begin
                // top of operator stack is in otop_reg
                if (curop_reg == OP_LPAR && !rpar_reg && !flush_reg)
                begin
                    if (ocnt_reg >= CW'(STACK_DEPTH))
                    begin
                        if (err_reg == ST_OK) err_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        opush     = 1'b1;
                        opush_d   = OP_LPAR;
                        ocnt_next = ocnt_reg + CW'(1);
                    end
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
                else if (flush_reg)
                begin
                    if (ocnt_reg == '0)
                        state_next = S_OUT;
                    else
                        state_next = S_OPRD;
                end
                else if (rpar_reg)
                begin
                    if (ocnt_reg == '0)
                        state_next = last_reg ? S_FIN : S_IDLE;
                    else if (topop == OP_LPAR)
                    begin
                        ocnt_next  = ocnt_reg - CW'(1);
                        state_next = last_reg ? S_FIN : S_IDLE;
                    end
                    else
                        state_next = S_OPRD;
                end
                else
                begin
                    if (ocnt_reg != '0 && op_prec(topop) >= op_prec(curop_reg))
                        state_next = S_OPRD;
                    else
                    begin
                        if (ocnt_reg >= CW'(STACK_DEPTH))
                        begin
                            if (err_reg == ST_OK) err_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            opush     = 1'b1;
                            opush_d   = curop_reg;
                            ocnt_next = ocnt_reg + CW'(1);
                        end
                        state_next = last_reg ? S_FIN : S_IDLE;
                    end
                end
            end
            S_OPRD:
            begin
                // pop operator and keep it for the arithmetic unit, popping operand b; a paren is dropped
                ocnt_next = ocnt_reg - CW'(1);
                exop_next = topop;
                if (topop == OP_LPAR)
                    state_next = S_CHECK;
                else
                begin
                    b_next = (vcnt_reg != '0) ? vtop_reg : '0;
                    if (vcnt_reg != '0) vcnt_next = vcnt_reg - CW'(1);
                    state_next = S_POPB;
                end
            end
            S_POPB:
            begin
                // vtop now reflects the next value
                state_next = S_POPA;
            end
            S_POPA:
            begin
                a_next = (vcnt_reg != '0) ? vtop_reg : '0;
                if (vcnt_reg != '0) vcnt_next = vcnt_reg - CW'(1);
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                areq.start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (arsp.done)
                begin
                    if (arsp.div_zero && err_reg == ST_OK)
                        err_next = ST_DIV_ZERO;
                    vpush_d = ares;
                    if (vcnt_reg >= CW'(STACK_DEPTH))
                    begin
                        if (err_reg == ST_OK && !arsp.div_zero)
                            err_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        vpush     = 1'b1;
                        vcnt_next = vcnt_reg + CW'(1);
                    end
                    state_next = S_CHECK;
                end
            end
            S_FIN:
            begin
                flush_next = 1'b1;
                if (innum_reg)
                begin
                    if (vcnt_reg >= CW'(STACK_DEPTH))
                    begin
                        if (err_reg == ST_OK) err_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        vpush     = 1'b1;
                        vcnt_next = vcnt_reg + CW'(1);
                    end
                    acc_next   = '0;
                    innum_next = 1'b0;
                end
                state_next = S_CHECK;
            end
            S_OUT:
            begin
                if (!out_valid_reg_set)
                begin
                    val_next   = (err_reg != ST_OK || vcnt_reg == '0) ? 32'd0
                               : 32'(signed'(vtop_reg));
                    st_next    = err_reg;
                    ocnt_next  = '0;
                    vcnt_next  = '0;
                    acc_next   = '0;
                    innum_next = 1'b0;
                    err_next   = ST_OK;
                    flush_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // output register
    assign out_valid_reg_set = out_valid_reg && !out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (state_reg == S_OUT && !out_valid_reg_set)
            out_valid_next = 1'b1;
    end

    // stack read addresses track the next count so the top is ready
    assign ord_addr = (ocnt_next == '0) ? '0 : AW'(ocnt_next - CW'(1));
    assign vrd_addr = (vcnt_next == '0) ? '0 : AW'(vcnt_next - CW'(1));

    // operator stack memory
    always_ff @(posedge clk)
    begin
        if (opush)
            ostk[AW'(ocnt_reg)] <= opush_d;
        otop_reg <= (opush) ? opush_d : ostk[ord_addr];
    end

    // value stack memory
    always_ff @(posedge clk)
    begin
        if (vpush)
            vstk[AW'(vcnt_reg)] <= vpush_d;
        vtop_reg <= (vpush) ? vpush_d : vstk[vrd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ocnt_reg      <= '0;
            vcnt_reg      <= '0;
            acc_reg       <= '0;
            innum_reg     <= 1'b0;
            err_reg       <= ST_OK;
            flush_reg     <= 1'b0;
            rpar_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ocnt_reg      <= ocnt_next;
            vcnt_reg      <= vcnt_next;
            acc_reg       <= acc_next;
            innum_reg     <= innum_next;
            err_reg       <= err_next;
            flush_reg     <= flush_next;
            rpar_reg      <= rpar_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            ch_reg   <= char_code;
            last_reg <= last_char;
        end
        curop_reg <= curop_next;
        exop_reg  <= exop_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        val_reg   <= val_next;
        st_reg    <= st_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = val_reg;
    assign status    = st_reg;

endmodule
